// ===== rtl/gonq_pkg.sv =====
`timescale 1ns / 1ps
// Package of the grid occupancy neighbour query block: word types, codes and states.
// It depends on nothing; the block and its checker import it.
package gonq_pkg;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_MOVE   = 2'd1,
    OP_QUERY  = 2'd2,
    OP_UNUSED = 2'd3
  } op_e;

  localparam logic [2:0] STAT_PLACED   = 3'd0;
  localparam logic [2:0] STAT_OCCUPIED = 3'd1;
  localparam logic [2:0] STAT_IGNORED  = 3'd2;
  localparam logic [2:0] STAT_NEIGHBOR = 3'd3;
  localparam logic [2:0] STAT_NONE     = 3'd4;

  localparam logic CFG_GRID_WIDTH  = 1'b0;
  localparam logic CFG_GRID_HEIGHT = 1'b1;

  localparam logic [6:0] CFG_RESET_DIM = 7'd64;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] occupant_id;
    logic [5:0] pos_x;
    logic [5:0] pos_y;
  } in_word_t;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] found_id;
    logic [5:0] cell_x;
    logic [5:0] cell_y;
    logic       last;
  } out_word_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_INS_CHK,
    S_MOVE_SCAN,
    S_MOVE_DRAIN,
    S_MOVE_PUT,
    S_QRY_SCAN,
    S_QRY_TAIL,
    S_QRY_END,
    S_EMIT
  } state_e;

endpackage

// ===== rtl/grid_occupancy_neighbor_query.sv =====
`timescale 1ns / 1ps
// Top level of the grid occupancy neighbour query block: grid memory, sequencer and output stage.
// It depends on gonq_pkg for the word types, codes and states.
//
// Usage:
// Input words (insert, move, query) arrive on in_valid_i / in_word_i and are taken when
// in_stall_o is low. Result words leave on out_valid_o / out_word_o and are taken when
// out_stall_i is low; last marks the final word of each input word.
// The grid lives in one memory of MAX_WIDTH * MAX_HEIGHT cells, one read and one write
// a cycle with a registered read, and one input word is worked on at a time.
// Insert: the cell is read, then written with the id if it is empty, and the result word is
// put into the output register; an ignored word goes straight to the output. Move: every cell
// of the active area (grid_width * grid_height) is scanned to clear the old cells, then the
// new cell is written. Query: the 25 window positions are read, then the last read and the final word.
// A result word that waits for a busy output register holds the sequence.
// The next input word can be taken in the cycle after the previous one has put its last word
// into the output register, even while that word is still stalled.
// After reset the block sweeps the whole grid of MAX_WIDTH * MAX_HEIGHT cells to empty,
// with in_stall_o high; configuration writes are taken at any time.
// While out_stall_i holds a word, that word stays put; a query pauses only on a hit it cannot pass on.
module grid_occupancy_neighbor_query #(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64,
  parameter int ID_BITS    = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  gonq_pkg::in_word_t  in_word_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output gonq_pkg::out_word_t out_word_o,
  input  logic              cfg_we_i,
  input  logic              cfg_idx_i,
  input  logic [6:0]        cfg_wdata_i
);
  import gonq_pkg::*;

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam logic [6:0]    WCAP     = 7'(MAX_WIDTH < 127 ? MAX_WIDTH : 127);
  localparam logic [6:0]    HCAP     = 7'(MAX_HEIGHT < 127 ? MAX_HEIGHT : 127);
  localparam logic [AW-1:0] LAST_CLR = AW'(DEPTH - 1);

  function automatic logic [AW-1:0] cell_addr(input logic [6:0] x, input logic [6:0] y);
    return AW'(y) * AW'(MAX_WIDTH) + AW'(x);
  endfunction

  logic [ID_BITS-1:0] mem [DEPTH];
  logic [ID_BITS-1:0] rd_data_q;
  logic               mem_we, mem_re;
  logic [AW-1:0]      mem_wa, mem_ra;
  logic [ID_BITS-1:0] mem_wd;

  state_e state_q, state_d;
  logic [6:0] grid_w_q, grid_h_q;
  logic [AW-1:0] clr_q, clr_d;
  logic [ID_BITS-1:0] id_q, id_d;
  logic [5:0] px_q, px_d, py_q, py_d;
  logic [6:0] col_q, col_d, row_q, row_d;
  logic [2:0] dx_q, dx_d, dy_q, dy_d;
  logic chk_q, chk_d;
  logic [AW-1:0] chk_addr_q, chk_addr_d;
  logic [5:0] qx_q, qx_d, qy_q, qy_d;
  logic pend_valid_q, pend_valid_d;
  out_word_t pend_q, pend_d, res_q, res_d, out_q, push_word;
  logic out_valid_q, out_push;

  logic [6:0] act_w, act_h;
  logic in_acc, in_inside, in_ok, out_free;
  logic [ID_BITS-1:0] in_id;
  logic move_last, win_last, win_ok, hit, q_hold, clr_last;
  logic signed [7:0] win_x, win_y;
  op_e in_op;

  assign act_w = (grid_w_q == 7'd0) ? 7'd1 : ((grid_w_q > WCAP) ? WCAP : grid_w_q);
  assign act_h = (grid_h_q == 7'd0) ? 7'd1 : ((grid_h_q > HCAP) ? HCAP : grid_h_q);

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign in_op      = op_e'(in_word_i.operation);
  assign in_id      = ID_BITS'(in_word_i.occupant_id);
  assign in_inside  = ({1'b0, in_word_i.pos_x} < act_w) && ({1'b0, in_word_i.pos_y} < act_h);
  assign in_ok      = (in_id != '0) && in_inside;
  assign out_free   = !out_valid_q || !out_stall_i;

  assign move_last = (col_q == act_w - 7'd1) && (row_q == act_h - 7'd1);
  assign win_x     = $signed({2'b00, px_q}) + $signed({5'b00000, dx_q}) - 8'sd2;
  assign win_y     = $signed({2'b00, py_q}) + $signed({5'b00000, dy_q}) - 8'sd2;
  assign win_ok    = !(dx_q == 3'd2 && dy_q == 3'd2) && !win_x[7] && !win_y[7] &&
                     (win_x[6:0] < act_w) && (win_y[6:0] < act_h);
  assign win_last  = (dx_q == 3'd4) && (dy_q == 3'd4);
  assign hit       = chk_q && (rd_data_q != '0);
  assign q_hold    = hit && pend_valid_q && !out_free;
  assign clr_last  = (clr_q == LAST_CLR);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR: begin
        if (clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_acc) begin
          unique case (in_op)
            OP_INSERT: state_d = in_ok ? S_INS_CHK : S_EMIT;
            OP_MOVE:   state_d = in_ok ? S_MOVE_SCAN : S_EMIT;
            OP_QUERY:  state_d = S_QRY_SCAN;
            default:   state_d = S_EMIT;
          endcase
        end
      end
      S_INS_CHK:    state_d = S_EMIT;
      S_MOVE_SCAN: begin
        if (move_last) state_d = S_MOVE_DRAIN;
      end
      S_MOVE_DRAIN: state_d = S_MOVE_PUT;
      S_MOVE_PUT:   state_d = S_EMIT;
      S_QRY_SCAN: begin
        if (!q_hold && win_last) state_d = S_QRY_TAIL;
      end
      S_QRY_TAIL: begin
        if (!q_hold) state_d = S_QRY_END;
      end
      S_QRY_END, S_EMIT: begin
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    clr_d        = clr_q;
    id_d         = id_q;
    px_d         = px_q;
    py_d         = py_q;
    col_d        = col_q;
    row_d        = row_q;
    dx_d         = dx_q;
    dy_d         = dy_q;
    chk_d        = chk_q;
    chk_addr_d   = chk_addr_q;
    qx_d         = qx_q;
    qy_d         = qy_q;
    pend_valid_d = pend_valid_q;
    pend_d       = pend_q;
    res_d        = res_q;
    mem_we       = 1'b0;
    mem_wa       = chk_addr_q;
    mem_wd       = '0;
    mem_re       = 1'b0;
    mem_ra       = chk_addr_q;
    out_push     = 1'b0;
    push_word    = res_q;
    unique case (state_q)
      S_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = clr_q;
        clr_d  = clr_q + AW'(1);
      end
      S_IDLE: begin
        if (in_acc) begin
          id_d         = in_id;
          px_d         = in_word_i.pos_x;
          py_d         = in_word_i.pos_y;
          col_d        = '0;
          row_d        = '0;
          dx_d         = '0;
          dy_d         = '0;
          chk_d        = 1'b0;
          pend_valid_d = 1'b0;
          res_d        = '{status: STAT_IGNORED, found_id: '0, cell_x: '0, cell_y: '0,
                           last: 1'b1};
          if (in_op == OP_INSERT && in_ok) begin
            mem_re = 1'b1;
            mem_ra = cell_addr({1'b0, in_word_i.pos_x}, {1'b0, in_word_i.pos_y});
          end
        end
      end
      S_INS_CHK: begin
        if (rd_data_q != '0) begin
          res_d = '{status: STAT_OCCUPIED, found_id: 8'(rd_data_q), cell_x: px_q,
                    cell_y: py_q, last: 1'b1};
        end else begin
          mem_we = 1'b1;
          mem_wa = cell_addr({1'b0, px_q}, {1'b0, py_q});
          mem_wd = id_q;
          res_d  = '{status: STAT_PLACED, found_id: 8'(id_q), cell_x: px_q,
                     cell_y: py_q, last: 1'b1};
        end
      end
      S_MOVE_SCAN, S_MOVE_DRAIN: begin
        if (chk_q && rd_data_q == id_q) begin
          mem_we = 1'b1;
          mem_wa = chk_addr_q;
        end
        chk_d = 1'b0;
        if (state_q == S_MOVE_SCAN) begin
          mem_re     = 1'b1;
          mem_ra     = cell_addr(col_q, row_q);
          chk_d      = 1'b1;
          chk_addr_d = cell_addr(col_q, row_q);
          if (col_q == act_w - 7'd1) begin
            col_d = '0;
            row_d = row_q + 7'd1;
          end else begin
            col_d = col_q + 7'd1;
          end
        end
      end
      S_MOVE_PUT: begin
        mem_we = 1'b1;
        mem_wa = cell_addr({1'b0, px_q}, {1'b0, py_q});
        mem_wd = id_q;
        res_d  = '{status: STAT_PLACED, found_id: 8'(id_q), cell_x: px_q,
                   cell_y: py_q, last: 1'b1};
      end
      S_QRY_SCAN, S_QRY_TAIL: begin
        if (!q_hold) begin
          if (hit) begin
            if (pend_valid_q) begin
              out_push  = 1'b1;
              push_word = pend_q;
            end
            pend_valid_d = 1'b1;
            pend_d = '{status: STAT_NEIGHBOR, found_id: 8'(rd_data_q), cell_x: qx_q,
                       cell_y: qy_q, last: 1'b0};
          end
          chk_d = 1'b0;
          if (state_q == S_QRY_SCAN) begin
            chk_d = win_ok;
            qx_d  = win_x[5:0];
            qy_d  = win_y[5:0];
            if (win_ok) begin
              mem_re = 1'b1;
              mem_ra = cell_addr(win_x[6:0], win_y[6:0]);
            end
            if (dx_q == 3'd4) begin
              dx_d = '0;
              dy_d = dy_q + 3'd1;
            end else begin
              dx_d = dx_q + 3'd1;
            end
          end
        end
      end
      S_QRY_END: begin
        if (out_free) begin
          out_push = 1'b1;
          if (pend_valid_q) begin
            push_word      = pend_q;
            push_word.last = 1'b1;
          end else begin
            push_word = '{status: STAT_NONE, found_id: '0, cell_x: '0, cell_y: '0,
                          last: 1'b1};
          end
        end
      end
      S_EMIT: begin
        if (out_free) out_push = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (mem_re) rd_data_q <= mem[mem_ra];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      clr_q        <= '0;
      grid_w_q     <= CFG_RESET_DIM;
      grid_h_q     <= CFG_RESET_DIM;
      chk_q        <= 1'b0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      clr_q        <= clr_d;
      chk_q        <= chk_d;
      pend_valid_q <= pend_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_GRID_WIDTH:  grid_w_q <= cfg_wdata_i;
          CFG_GRID_HEIGHT: grid_h_q <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (out_push) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    id_q       <= id_d;
    px_q       <= px_d;
    py_q       <= py_d;
    col_q      <= col_d;
    row_q      <= row_d;
    dx_q       <= dx_d;
    dy_q       <= dy_d;
    chk_addr_q <= chk_addr_d;
    qx_q       <= qx_d;
    qy_q       <= qy_d;
    pend_q     <= pend_d;
    res_q      <= res_d;
    if (out_push) out_q <= push_word;
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

// ===== rtl/gonq_checker.sv =====
`timescale 1ns / 1ps
// Port checker of the grid occupancy neighbour query block, bound to its top level.
// It depends on gonq_pkg for the word types and status codes.
module gonq_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input gonq_pkg::out_word_t out_word_o
);
  import gonq_pkg::*;

  // A stalled result word stays valid and unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_word_o))
    else $error("stalled result word changed");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_word_o.status == STAT_PLACED) ||
                    (out_word_o.status == STAT_OCCUPIED) ||
                    (out_word_o.status == STAT_IGNORED) ||
                    (out_word_o.status == STAT_NEIGHBOR) ||
                    (out_word_o.status == STAT_NONE))
    else $error("undefined status code");

  // Only a neighbour word can be followed by more words of the same query.
  a_single_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_word_o.status != STAT_NEIGHBOR) |-> out_word_o.last)
    else $error("single result word without last");

  a_empty_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && ((out_word_o.status == STAT_IGNORED) ||
                    (out_word_o.status == STAT_NONE))
    |-> (out_word_o.found_id == '0) && (out_word_o.cell_x == '0) &&
        (out_word_o.cell_y == '0))
    else $error("unused result fields not zero");

  // One word is worked on at a time, so the input stalls right after a take.
  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken twice in a row");

endmodule

bind grid_occupancy_neighbor_query gonq_checker u_gonq_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_word_o  (out_word_o)
);
